// ----- rtl/pcp_pkg.sv -----
// pcp_pkg: command and status codes shared by the polyhedron test block.
// No dependencies.
`timescale 1ns / 1ps
package pcp_pkg;
	localparam int CMD_W = 3;
	localparam int STAT_W = 2;
	localparam int CRN_W = 8;
	localparam int CIN_W = 16;

	typedef logic [CMD_W-1:0] cmd_t;
	typedef logic [STAT_W-1:0] stat_t;

	localparam cmd_t CMD_ADD_VERTEX = 3'd0;
	localparam cmd_t CMD_ADD_FACE   = 3'd1;
	localparam cmd_t CMD_CLEAR      = 3'd2;
	localparam cmd_t CMD_QUERY      = 3'd3;
	localparam cmd_t CMD_CONVEX     = 3'd4;

	localparam stat_t STAT_OK        = 2'd0;
	localparam stat_t STAT_FULL      = 2'd1;
	localparam stat_t STAT_BADCORNER = 2'd2;
endpackage

// ----- rtl/pcp_if.sv -----
// pcp_if: valid/ready channels for command beats and result beats.
// Depends on pcp_pkg.
`timescale 1ns / 1ps
interface pcp_req_if import pcp_pkg::*; ();
	logic                    valid;
	logic                    ready;
	cmd_t                    command;
	logic signed [CIN_W-1:0] coord_x;
	logic signed [CIN_W-1:0] coord_y;
	logic signed [CIN_W-1:0] coord_z;
	logic [CRN_W-1:0]        corner_a;
	logic [CRN_W-1:0]        corner_b;
	logic [CRN_W-1:0]        corner_c;
	modport source (output valid, command, coord_x, coord_y, coord_z,
		corner_a, corner_b, corner_c, input ready);
	modport sink (input valid, command, coord_x, coord_y, coord_z,
		corner_a, corner_b, corner_c, output ready);
endinterface

interface pcp_rsp_if import pcp_pkg::*; ();
	logic  valid;
	logic  ready;
	logic  verdict;
	stat_t status;
	modport source (output valid, verdict, status, input ready);
	modport sink (input valid, verdict, status, output ready);
endinterface

// ----- rtl/point_in_convex_polyhedron.sv -----
// point_in_convex_polyhedron: vertex/face tables with half-space point query
// and convexity check. Depends on pcp_pkg, pcp_if (channels), pcp_ram.
//
//  channel | dir | beat contents                                  | handshake
//  req     | in  | command, coord_x/y/z, corner_a/b/c             | valid/ready
//  rsp     | out | verdict, status                                | valid/ready
//
// Timing: append, clear and unused codes set the result register as the
// command beat is taken; S_WAIT then moves it to the output register once the
// output slot is free, and the next beat is taken after that. A query result
// follows the face loop, which ends early on the first failing face: one vertex
// RAM port serves three reads per face, one shared multiplier does six
// cross-product and six dot-product partial products. A convexity check runs
// the face loop once per vertex pair and skips it for a pair of equal vertices.
// Reset clears counts and control only; table contents are undefined.
// The result register lets a new command beat in while the last result waits.
`timescale 1ns / 1ps
module point_in_convex_polyhedron import pcp_pkg::*; #(
	parameter int MAX_VERTICES = 256,
	parameter int MAX_FACES    = 256,
	parameter int COORD_BITS   = 16
) (
	input logic     clk,
	input logic     arst_n,
	pcp_req_if.sink req,
	pcp_rsp_if.source rsp
);
	localparam int CB  = COORD_BITS;
	localparam int VA  = $clog2(MAX_VERTICES);
	localparam int FA  = $clog2(MAX_FACES);
	localparam int VCW = $clog2(MAX_VERTICES + 1);
	localparam int FCW = $clog2(MAX_FACES + 1);
	localparam int KW  = (VCW > CRN_W) ? VCW : CRN_W;
	localparam int MA  = CB + 2;        // multiplier operand width
	localparam int PW  = 2 * MA;        // product width
	localparam int NW  = 2 * CB + 3;    // normal component width
	localparam int NL  = CB + 1;        // low split of a normal component
	localparam int AW  = 3 * CB + 7;    // dot product accumulator

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_PAIR = 2'd1;
	localparam logic [1:0] S_FACE = 2'd2;
	localparam logic [1:0] S_WAIT = 2'd3;

	localparam logic [4:0] STP_CHECK = 5'd19;

	logic [1:0]     state_q;
	logic [4:0]     stp_q;
	logic           conv_q;
	logic [VCW-1:0] vcnt_q, pi_q, pj_q;
	logic [FCW-1:0] fcnt_q, fidx_q;
	logic           out_valid_q;

	// datapath
	logic [VA-1:0]          k1_q, k2_q;
	logic signed [CB-1:0]   v0_q [3];
	logic signed [CB-1:0]   va_q [3];
	logic signed [CB:0]     e1_q [3];
	logic signed [CB:0]     e2_q [3];
	logic signed [CB:0]     p2_q [3];
	logic signed [MA-1:0]   d_q  [3];
	logic signed [NW-1:0]   n_q  [3];
	logic signed [PW-1:0]   p_q;
	logic signed [AW-1:0]   acc_q;
	logic                   res_verdict_q, out_verdict_q;
	stat_t                  res_status_q, out_status_q;

	// RAM ports
	logic [3*CB-1:0] vrd, vwd;
	logic [3*VA-1:0] frd, fwd;
	logic [VA-1:0]   vraddr;
	logic            vwe, fwe;
	logic signed [CB-1:0] vd [3];
	logic signed [CB-1:0] cin [3];

	logic acc_in, vfull, ffull, badc, slot_free;
	logic face_done, face_fail, pair_eq, pair_adv, pair_last, pj_last;
	logic res_set, res_v;
	stat_t res_s;
	logic signed [MA-1:0] ma, mb;

	assign req.ready  = (state_q == S_IDLE);
	assign acc_in     = req.valid && req.ready;
	assign slot_free  = !out_valid_q || rsp.ready;
	assign rsp.valid  = out_valid_q;
	assign rsp.verdict = out_verdict_q;
	assign rsp.status = out_status_q;

	assign cin[0] = $signed(CB'($unsigned(req.coord_x)));
	assign cin[1] = $signed(CB'($unsigned(req.coord_y)));
	assign cin[2] = $signed(CB'($unsigned(req.coord_z)));

	assign vd[0] = $signed(vrd[CB-1:0]);
	assign vd[1] = $signed(vrd[2*CB-1:CB]);
	assign vd[2] = $signed(vrd[3*CB-1:2*CB]);

	assign vfull = (vcnt_q == VCW'(MAX_VERTICES));
	assign ffull = (fcnt_q == FCW'(MAX_FACES));
	assign badc  = (KW'(req.corner_a) >= KW'(vcnt_q)) ||
		(KW'(req.corner_b) >= KW'(vcnt_q)) || (KW'(req.corner_c) >= KW'(vcnt_q));

	assign vwe = acc_in && (req.command == CMD_ADD_VERTEX) && !vfull;
	assign vwd = {cin[2], cin[1], cin[0]};
	assign fwe = acc_in && (req.command == CMD_ADD_FACE) && !ffull && !badc;
	assign fwd = {VA'(req.corner_c), VA'(req.corner_b), VA'(req.corner_a)};

	// sequencer events
	assign face_done = (state_q == S_FACE) && (stp_q == 5'd0) && (fidx_q == fcnt_q);
	assign face_fail = (state_q == S_FACE) && (stp_q == STP_CHECK) && acc_q[AW-1];
	assign pair_eq   = (state_q == S_PAIR) && (stp_q == 5'd2) &&
		(va_q[0] == vd[0]) && (va_q[1] == vd[1]) && (va_q[2] == vd[2]);
	assign pair_adv  = pair_eq || (face_done && conv_q);
	assign pj_last   = (VCW'(pj_q + 1'b1) == vcnt_q);
	assign pair_last = pj_last && (VCW'(pi_q + 1'b1) == pj_q);

	always_comb begin
		vraddr = pi_q[VA-1:0];
		case (state_q)
			S_PAIR: vraddr = (stp_q == 5'd0) ? pi_q[VA-1:0] : pj_q[VA-1:0];
			S_FACE: begin
				if (stp_q == 5'd1) vraddr = frd[VA-1:0];
				else if (stp_q == 5'd2) vraddr = k1_q;
				else vraddr = k2_q;
			end
			default: vraddr = pi_q[VA-1:0];
		endcase
	end

	pcp_ram #(.WIDTH(3 * CB), .DEPTH(MAX_VERTICES)) u_vram (
		.clk(clk), .wr_en(vwe), .wr_addr(vcnt_q[VA-1:0]), .wr_data(vwd),
		.rd_addr(vraddr), .rd_data(vrd)
	);

	pcp_ram #(.WIDTH(3 * VA), .DEPTH(MAX_FACES)) u_fram (
		.clk(clk), .wr_en(fwe), .wr_addr(fcnt_q[FA-1:0]), .wr_data(fwd),
		.rd_addr(fidx_q[FA-1:0]), .rd_data(frd)
	);

	// result decision
	always_comb begin
		res_set = 1'b0;
		res_v   = 1'b0;
		res_s   = STAT_OK;
		if (acc_in) begin
			case (req.command)
				CMD_ADD_VERTEX: begin
					res_set = 1'b1;
					res_s   = vfull ? STAT_FULL : STAT_OK;
				end
				CMD_ADD_FACE: begin
					res_set = 1'b1;
					if (ffull) res_s = STAT_FULL;
					else if (badc) res_s = STAT_BADCORNER;
				end
				CMD_QUERY: res_set = 1'b0;
				CMD_CONVEX: begin
					res_set = (vcnt_q < VCW'(2));
					res_v   = 1'b1;
				end
				default: res_set = 1'b1;
			endcase
		end else if (face_done && !conv_q) begin
			res_set = 1'b1;
			res_v   = 1'b1;
		end else if (pair_adv && pair_last) begin
			res_set = 1'b1;
			res_v   = 1'b1;
		end else if (face_fail) begin
			res_set = 1'b1;
		end
	end

	// shared multiplier operand select: cross product, then split dot product
	always_comb begin
		ma = '0;
		mb = '0;
		case (stp_q)
			5'd5:  begin ma = MA'(e1_q[1]); mb = MA'(e2_q[2]); end
			5'd6:  begin ma = MA'(e1_q[2]); mb = MA'(e2_q[1]); end
			5'd7:  begin ma = MA'(e1_q[2]); mb = MA'(e2_q[0]); end
			5'd8:  begin ma = MA'(e1_q[0]); mb = MA'(e2_q[2]); end
			5'd9:  begin ma = MA'(e1_q[0]); mb = MA'(e2_q[1]); end
			5'd10: begin ma = MA'(e1_q[1]); mb = MA'(e2_q[0]); end
			5'd12: begin ma = d_q[0]; mb = $signed({1'b0, n_q[0][NL-1:0]}); end
			5'd13: begin ma = d_q[0]; mb = $signed(n_q[0][NW-1:NL]); end
			5'd14: begin ma = d_q[1]; mb = $signed({1'b0, n_q[1][NL-1:0]}); end
			5'd15: begin ma = d_q[1]; mb = $signed(n_q[1][NW-1:NL]); end
			5'd16: begin ma = d_q[2]; mb = $signed({1'b0, n_q[2][NL-1:0]}); end
			5'd17: begin ma = d_q[2]; mb = $signed(n_q[2][NW-1:NL]); end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			stp_q       <= '0;
			conv_q      <= 1'b0;
			vcnt_q      <= '0;
			fcnt_q      <= '0;
			fidx_q      <= '0;
			pi_q        <= '0;
			pj_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_WAIT && slot_free) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (acc_in) begin
						state_q <= S_WAIT;
						stp_q   <= '0;
						fidx_q  <= '0;
						case (req.command)
							CMD_ADD_VERTEX: if (!vfull) vcnt_q <= VCW'(vcnt_q + 1'b1);
							CMD_ADD_FACE: if (fwe) fcnt_q <= FCW'(fcnt_q + 1'b1);
							CMD_CLEAR: begin
								vcnt_q <= '0;
								fcnt_q <= '0;
							end
							CMD_QUERY: begin
								state_q <= S_FACE;
								conv_q  <= 1'b0;
							end
							CMD_CONVEX: begin
								conv_q <= 1'b1;
								pi_q   <= '0;
								pj_q   <= VCW'(1);
								if (vcnt_q >= VCW'(2)) state_q <= S_PAIR;
							end
							default: state_q <= S_WAIT;
						endcase
					end
				end
				S_PAIR, S_FACE: begin
					if (pair_adv) begin
						stp_q <= '0;
						if (pair_last) begin
							state_q <= S_WAIT;
						end else begin
							state_q <= S_PAIR;
							if (pj_last) begin
								pi_q <= VCW'(pi_q + 1'b1);
								pj_q <= VCW'(pi_q + 2'd2);
							end else begin
								pj_q <= VCW'(pj_q + 1'b1);
							end
						end
					end else if (face_done || face_fail) begin
						state_q <= S_WAIT;
					end else if (state_q == S_PAIR && stp_q == 5'd2) begin
						state_q <= S_FACE;
						stp_q   <= '0;
						fidx_q  <= '0;
					end else if (state_q == S_FACE && stp_q == STP_CHECK) begin
						fidx_q <= FCW'(fidx_q + 1'b1);
						stp_q  <= '0;
					end else begin
						stp_q <= stp_q + 1'b1;
					end
				end
				S_WAIT: if (slot_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		p_q <= ma * mb;
		if (res_set) begin
			res_verdict_q <= res_v;
			res_status_q  <= res_s;
		end
		if (state_q == S_WAIT && slot_free) begin
			out_verdict_q <= res_verdict_q;
			out_status_q  <= res_status_q;
		end
		if (acc_in) begin
			for (int i = 0; i < 3; i++) p2_q[i] <= $signed({cin[i], 1'b0});
		end
		if (state_q == S_PAIR) begin
			if (stp_q == 5'd1) begin
				for (int i = 0; i < 3; i++) va_q[i] <= vd[i];
			end
			if (stp_q == 5'd2) begin
				for (int i = 0; i < 3; i++)
					p2_q[i] <= (CB + 1)'(va_q[i]) + (CB + 1)'(vd[i]);
			end
		end
		if (state_q == S_FACE) begin
			case (stp_q)
				5'd1: begin
					k1_q <= frd[2*VA-1:VA];
					k2_q <= frd[3*VA-1:2*VA];
				end
				5'd2: for (int i = 0; i < 3; i++) v0_q[i] <= vd[i];
				5'd3: begin
					for (int i = 0; i < 3; i++) begin
						e1_q[i] <= (CB + 1)'(vd[i]) - (CB + 1)'(v0_q[i]);
						d_q[i]  <= $signed({v0_q[i][CB-1], v0_q[i], 1'b0}) - MA'(p2_q[i]);
					end
				end
				5'd4: for (int i = 0; i < 3; i++)
					e2_q[i] <= (CB + 1)'(vd[i]) - (CB + 1)'(v0_q[i]);
				5'd6:  n_q[0] <= NW'(p_q);
				5'd7:  n_q[0] <= n_q[0] - NW'(p_q);
				5'd8:  n_q[1] <= NW'(p_q);
				5'd9:  n_q[1] <= n_q[1] - NW'(p_q);
				5'd10: n_q[2] <= NW'(p_q);
				5'd11: n_q[2] <= n_q[2] - NW'(p_q);
				5'd13: acc_q <= AW'(p_q);
				5'd14, 5'd16, 5'd18: acc_q <= acc_q + (AW'(p_q) <<< NL);
				5'd15, 5'd17: acc_q <= acc_q + AW'(p_q);
				default: acc_q <= acc_q;
			endcase
		end
	end
endmodule

// ----- rtl/pcp_ram.sv -----
// pcp_ram: generic one-write, one-read synchronous RAM, registered read.
// No dependencies.
`timescale 1ns / 1ps
module pcp_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end
endmodule
